/* src/slt_pkg.sv */
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and constants of the sequential list table: action codes,
// field widths, the probe record that walks the cell chain and the shift
// command broadcast to every cell.
// ----------------------------------------------------------------------------
package slt_pkg;

   localparam int CAPACITY = 64;
   localparam int ACTION_W = 3;
   localparam int POS_W    = 7;
   localparam int DATA_W   = 32;

   typedef logic [POS_W-1:0]         pos_type;
   typedef logic signed [DATA_W-1:0] data_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR  = 3'd0,
      ACT_FIND   = 3'd1,
      ACT_SITE   = 3'd2,
      ACT_INSERT = 3'd3,
      ACT_DELETE = 3'd4,
      ACT_GET    = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      PRB_FIND,
      PRB_SITE,
      PRB_READ
   } probe_mode_type;

   typedef enum logic [1:0] {
      SH_NONE,
      SH_INSERT,
      SH_REMOVE
   } shift_op_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic           active;
      probe_mode_type mode;
      data_type       key;
      pos_type        pos;
      logic           hit;
      pos_type        index;
      data_type       element;
   } probe_type;

   typedef struct packed {
      shift_op_type op;
      pos_type      pos;
      data_type     value;
      pos_type      count;
   } shift_cmd_type;

   typedef struct packed {
      logic     ok;
      pos_type  index;
      data_type element;
      pos_type  count;
   } result_type;

endpackage

/* src/slt_req_if.sv */
// ----------------------------------------------------------------------------
// slt_req_if
// Request channel of the list table: valid/ready handshake with the action,
// position and value of one request.
// ----------------------------------------------------------------------------
interface slt_req_if;
   logic                valid;
   logic                ready;
   logic [2:0]          action;
   logic [6:0]          position;
   logic signed [31:0]  value;

   modport source (output valid, output action, output position, output value,
                   input ready);
   modport sink   (input valid, input action, input position, input value,
                   output ready);
endinterface

/* src/slt_rsp_if.sv */
// ----------------------------------------------------------------------------
// slt_rsp_if
// Result channel of the list table: valid/ready handshake with the status,
// index, element and element count of one result.
// ----------------------------------------------------------------------------
interface slt_rsp_if;
   logic                valid;
   logic                ready;
   logic                ok;
   logic [6:0]          index;
   logic signed [31:0]  element;
   logic [6:0]          count;

   modport source (output valid, output ok, output index, output element,
                   output count, input ready);
   modport sink   (input valid, input ok, input index, input element,
                   input count, output ready);
endinterface

/* src/sequential_list_table.sv */
// ----------------------------------------------------------------------------
// sequential_list_table
// Ordered list of up to CAPACITY signed 32-bit elements held in a chain of
// cells, with clear, find, find-site, insert, delete and get requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_ch (action, position, value) and each one yields
//   exactly one result on rsp_ch (ok, index, element, count).
//   Clear, insert, and get or delete with a position not below the count
//   answer with the result registered in the cycle after the request is taken.
//   Find, find-site, and a valid get or delete send a probe down the chain
//   of CAPACITY cells, one cell per cycle, after the head register; the
//   result registers once the probe leaves the last cell. Delete shifts the
//   later elements down in the cycle that its result is written.
//   One request is in work at a time: one request per cycle for the short
//   actions while rsp_ch.ready is high; none during a scan's probe walk.
//   The result register frees req_ch.ready again in the cycle the receiver
//   takes the waiting result; while rsp_ch.ready is low the result holds
//   and no further request is taken.
//   Reset empties the list and drops any pending probe or result; element
//   storage is not cleared, only the count.
// ----------------------------------------------------------------------------
module sequential_list_table (
   input  logic clock,
   input  logic reset,
   slt_req_if.sink   req_ch,
   slt_rsp_if.source rsp_ch
);
   import slt_pkg::*;

   state_type     state_ff, state_in;
   pos_type       count_ff, count_in;
   logic          del_ff, del_in;
   probe_type     head_ff, head_in;
   result_type    rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_load;
   logic          req_fire;
   logic          insert_ok;
   logic          pos_valid;
   shift_cmd_type cmd;
   probe_type     tail;

   data_type  cell_elem  [CAPACITY];
   probe_type cell_probe [CAPACITY];

   assign req_ch.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign insert_ok    = (req_ch.position <= count_ff) && (count_ff < POS_W'(CAPACITY));
   assign pos_valid    = req_ch.position < count_ff;
   assign tail         = cell_probe[CAPACITY-1];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_ch.action)
                  ACT_FIND, ACT_SITE: state_in = ST_SCAN;
                  ACT_DELETE, ACT_GET: begin
                     if (pos_valid) state_in = ST_SCAN;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            if (tail.active) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in       = count_ff;
      del_in         = del_ff;
      head_in        = head_ff;
      head_in.active = 1'b0;
      rsp_load       = 1'b0;
      rsp_in         = rsp_ff;
      cmd.op         = SH_NONE;
      cmd.pos        = req_ch.position;
      cmd.value      = req_ch.value;
      cmd.count      = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_in  = '{ok: 1'b0, index: '0, element: '0, count: count_ff};
               head_in = '{active: 1'b1, mode: PRB_FIND, key: req_ch.value,
                           pos: req_ch.position, hit: 1'b0, index: '0,
                           element: '0};
               case (req_ch.action)
                  ACT_CLEAR: begin
                     count_in     = '0;
                     rsp_load     = 1'b1;
                     rsp_in.ok    = 1'b1;
                     rsp_in.count = '0;
                     head_in.active = 1'b0;
                  end
                  ACT_FIND: head_in.mode = PRB_FIND;
                  ACT_SITE: head_in.mode = PRB_SITE;
                  ACT_INSERT: begin
                     head_in.active = 1'b0;
                     rsp_load       = 1'b1;
                     if (insert_ok) begin
                        cmd.op       = SH_INSERT;
                        count_in     = count_ff + 1'b1;
                        rsp_in.ok    = 1'b1;
                        rsp_in.count = count_ff + 1'b1;
                     end
                  end
                  ACT_DELETE, ACT_GET: begin
                     head_in.mode = PRB_READ;
                     del_in       = (req_ch.action == ACT_DELETE);
                     if (!pos_valid) begin
                        head_in.active = 1'b0;
                        rsp_load       = 1'b1;
                     end
                  end
                  default: begin
                     head_in.active = 1'b0;
                     rsp_load       = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (tail.active) begin
               rsp_load = 1'b1;
               rsp_in   = '{ok: 1'b0, index: '0, element: '0, count: count_ff};
               case (tail.mode)
                  PRB_FIND: begin
                     rsp_in.ok    = tail.hit;
                     rsp_in.index = tail.hit ? tail.index : '0;
                  end
                  PRB_SITE: begin
                     // no larger element and no free slot: site is the count
                     rsp_in.ok    = 1'b1;
                     rsp_in.index = tail.hit ? tail.index : count_ff;
                  end
                  PRB_READ: begin
                     rsp_in.ok      = 1'b1;
                     rsp_in.element = tail.element;
                     if (del_ff) begin
                        cmd.op       = SH_REMOVE;
                        cmd.pos      = tail.pos;
                        count_in     = count_ff - 1'b1;
                        rsp_in.count = count_ff - 1'b1;
                     end
                  end
                  default: rsp_in.ok = 1'b0;
               endcase
            end
         end
         default: rsp_load = 1'b0;
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         del_ff       <= 1'b0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         del_ff       <= del_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) rsp_ff <= rsp_in;
   end

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      slt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .my_index   (POS_W'(k)),
         .cmd        (cmd),
         .left_elem  ((k == 0) ? cell_elem[0] : cell_elem[(k == 0) ? 0 : k-1]),
         .right_elem (cell_elem[(k == CAPACITY-1) ? k : k+1]),
         .probe_in   ((k == 0) ? head_ff : cell_probe[(k == 0) ? 0 : k-1]),
         .elem       (cell_elem[k]),
         .probe_out  (cell_probe[k])
      );
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.ok      = rsp_ff.ok;
   assign rsp_ch.index   = rsp_ff.index;
   assign rsp_ch.element = rsp_ff.element;
   assign rsp_ch.count   = rsp_ff.count;

endmodule

/* src/slt_cell.sv */
// ----------------------------------------------------------------------------
// slt_cell
// One slot of the list. Holds one element, shifts it to or from a neighbor
// on insert and remove, and registers the probe record on its way down the
// chain after checking its own element against it.
// ----------------------------------------------------------------------------
module slt_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  slt_pkg::pos_type       my_index,
   input  slt_pkg::shift_cmd_type cmd,
   input  slt_pkg::data_type      left_elem,
   input  slt_pkg::data_type      right_elem,
   input  slt_pkg::probe_type     probe_in,
   output slt_pkg::data_type      elem,
   output slt_pkg::probe_type     probe_out
);
   import slt_pkg::*;

   data_type  elem_ff, elem_in;
   probe_type probe_ff, probe_in_nx;
   logic      occupied;
   logic      below_last;

   assign occupied   = my_index < cmd.count;
   assign below_last = ({1'b0, my_index} + {{POS_W{1'b0}}, 1'b1}) < {1'b0, cmd.count};

   always_comb begin
      elem_in = elem_ff;
      case (cmd.op)
         SH_INSERT: begin
            if (my_index == cmd.pos) begin
               elem_in = cmd.value;
            end else if (my_index > cmd.pos && my_index <= cmd.count) begin
               elem_in = left_elem;
            end
         end
         SH_REMOVE: begin
            // pull the right neighbor down over the removed slot
            if (my_index >= cmd.pos && below_last) begin
               elem_in = right_elem;
            end
         end
         default: elem_in = elem_ff;
      endcase
   end

   always_comb begin
      probe_in_nx = probe_in;
      if (probe_in.active && !probe_in.hit) begin
         case (probe_in.mode)
            PRB_FIND: begin
               if (occupied && elem_ff == probe_in.key) begin
                  probe_in_nx.hit   = 1'b1;
                  probe_in_nx.index = my_index;
               end
            end
            PRB_SITE: begin
               if (!occupied || $signed(probe_in.key) < $signed(elem_ff)) begin
                  probe_in_nx.hit   = 1'b1;
                  probe_in_nx.index = my_index;
               end
            end
            PRB_READ: begin
               if (my_index == probe_in.pos) begin
                  probe_in_nx.hit     = 1'b1;
                  probe_in_nx.element = elem_ff;
               end
            end
            default: probe_in_nx = probe_in;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      elem_ff <= elem_in;
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in_nx;
      end
   end

   assign elem      = elem_ff;
   assign probe_out = probe_ff;

endmodule
